// File: rtl/mlcs_pkg.sv
// shared types, constants and codes for the min-max contrast stretch block
package mlcs_pkg;

    localparam int PIX_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int NUM_W   = PIX_W + LEVEL_W;
    localparam int STEP_W  = $clog2(LEVEL_W);

    localparam logic [PIX_W-1:0]   PIX_MAX   = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(LEVEL_W - 1);

    // input request payload
    typedef struct packed {
        logic             kind;
        logic             first;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } in_t;

    // result payload
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               frame_end;
    } out_t;

    // pixel kinds
    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_MAP     = 1'b1;

    // how the level of a map pixel is formed
    typedef enum logic [1:0] {
        MODE_DIV,
        MODE_ZERO,
        MODE_FULL
    } mode_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_bounds;
        logic load_div;
        logic step_div;
        logic load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

// File: rtl/mlcs_datapath.sv
// datapath: running bounds, scaled numerator and restoring divider, result register
module mlcs_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  mlcs_pkg::in_t      req,
    input  mlcs_pkg::cmd_t     cmd,
    output mlcs_pkg::status_t  status,
    output mlcs_pkg::out_t     result
);

    logic [mlcs_pkg::PIX_W-1:0]   low_reg,  low_next;
    logic [mlcs_pkg::PIX_W-1:0]   high_reg, high_next;
    logic [mlcs_pkg::NUM_W-1:0]   rem_reg,  rem_next;
    logic [mlcs_pkg::NUM_W-1:0]   div_reg,  div_next;
    logic [mlcs_pkg::LEVEL_W-1:0] quo_reg,  quo_next;
    logic [mlcs_pkg::STEP_W-1:0]  step_reg, step_next;
    mlcs_pkg::mode_t              mode_reg, mode_next;
    logic                         last_reg, last_next;
    mlcs_pkg::out_t               out_reg,  out_next;

    logic [mlcs_pkg::PIX_W-1:0]   offset;
    logic [mlcs_pkg::PIX_W-1:0]   span;
    logic [mlcs_pkg::NUM_W-1:0]   num;
    logic [mlcs_pkg::NUM_W-1:0]   rem_diff;
    logic                         rem_ge;
    logic [mlcs_pkg::LEVEL_W-1:0] level_sel;

    // scaled offset: 255 * (pixel - low) as (x << 8) - x
    assign offset   = req.pixel - low_reg;
    assign span     = high_reg - low_reg;
    assign num      = {offset, mlcs_pkg::LEVEL_W'(0)} - mlcs_pkg::NUM_W'(offset);

    // one restoring divide step
    assign rem_diff = rem_reg - div_reg;
    assign rem_ge   = (rem_reg >= div_reg);

    assign status.div_last = (step_reg == '0);

    // level selection for the finished item
    always_comb begin
        case (mode_reg)
            mlcs_pkg::MODE_DIV:  level_sel = quo_reg;
            mlcs_pkg::MODE_FULL: level_sel = mlcs_pkg::LEVEL_MAX;
            default:             level_sel = '0;
        endcase
    end

    // next-state logic
    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        mode_next = mode_reg;
        last_next = last_reg;
        out_next  = out_reg;

        // measure pass: track running minimum and maximum
        if (cmd.load_bounds) begin
            if (req.first) begin
                low_next  = req.pixel;
                high_next = req.pixel;
            end else begin
                if (req.pixel <= low_reg) begin
                    low_next = req.pixel;
                end
                if (req.pixel >= high_reg) begin
                    high_next = req.pixel;
                end
            end
        end

        // map pass: set up the divide and the saturation case
        if (cmd.load_div) begin
            rem_next  = num;
            div_next  = {1'b0, span, (mlcs_pkg::LEVEL_W-1)'(0)};
            quo_next  = '0;
            step_next = mlcs_pkg::STEP_LAST;
            last_next = req.last;
            if (high_reg <= low_reg) begin
                mode_next = mlcs_pkg::MODE_ZERO;
            end else if (req.pixel < low_reg) begin
                mode_next = mlcs_pkg::MODE_ZERO;
            end else if (req.pixel > high_reg) begin
                mode_next = mlcs_pkg::MODE_FULL;
            end else begin
                mode_next = mlcs_pkg::MODE_DIV;
            end
        end

        // one quotient bit per cycle, most significant first
        if (cmd.step_div) begin
            if (rem_ge) begin
                rem_next = rem_diff;
            end
            quo_next  = {quo_reg[mlcs_pkg::LEVEL_W-2:0], rem_ge};
            div_next  = div_reg >> 1;
            step_next = step_reg - 1'b1;
        end

        // finished result into the output register
        if (cmd.load_out) begin
            out_next.level     = level_sel;
            out_next.frame_end = last_reg;
        end
    end

    // bounds carry a reset value, the rest is payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= mlcs_pkg::PIX_MAX;
            high_reg <= '0;
        end else begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        mode_reg <= mode_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign result = out_reg;

endmodule

// File: rtl/mlcs_ctrl.sv
// controller: request acceptance, divide sequencing and result handshake
module mlcs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               req_kind,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  mlcs_pkg::status_t  status,
    output mlcs_pkg::cmd_t     cmd
);

    mlcs_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    // state register and output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mlcs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;

        case (state_reg)
            mlcs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (req_kind == mlcs_pkg::KIND_MAP) begin
                        cmd.load_div = 1'b1;
                        state_next   = mlcs_pkg::ST_DIV;
                    end else begin
                        cmd.load_bounds = 1'b1;
                    end
                end
            end
            mlcs_pkg::ST_DIV: begin
                cmd.step_div = 1'b1;
                if (status.div_last) begin
                    state_next = mlcs_pkg::ST_DONE;
                end
            end
            mlcs_pkg::ST_DONE: begin
                // wait until the output register is free
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = mlcs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mlcs_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when taken
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// File: rtl/minmax_linear_contrast_stretch.sv
// min-max linear contrast stretch, 16-bit pixels to 8-bit levels
// measure request: updates running bounds, no result, block stays ready
// map request: 8 divide steps, then the result goes into the output register
//   (later while the previous result waits on m_ready); no new request is
//   taken until the result is loaded
// the divide is an 8-step restoring divider, one quotient bit per cycle
// reset (aresetn low, synchronous): idle, no result pending, bounds 65535 / 0
module minmax_linear_contrast_stretch (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mlcs_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output mlcs_pkg::out_t  m_data
);

    mlcs_pkg::cmd_t    cmd;
    mlcs_pkg::status_t status;

    // sequencing
    mlcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .req_kind (s_data.kind),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    mlcs_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (s_data),
        .cmd     (cmd),
        .status  (status),
        .result  (m_data)
    );

endmodule

// File: rtl/mlcs_checker.sv
// port-level checks for the contrast stretch block, bound to the top level
module mlcs_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input mlcs_pkg::in_t   s_data,
    input logic            m_valid,
    input logic            m_ready,
    input mlcs_pkg::out_t  m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a measure request never creates a result
    a_measure_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && s_valid && s_ready && s_data.kind == mlcs_pkg::KIND_MEASURE
        |=> !m_valid)
        else $error("measure request produced a result");

    // busy at the first and the last divide step after a map request
    a_map_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind == mlcs_pkg::KIND_MAP
        |=> !s_ready ##7 !s_ready)
        else $error("request taken during divide");

    // a flat or below-range level never exceeds the 8-bit range by construction;
    // a fresh result after a map request is not shown at the first divide step
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && s_valid && s_ready && s_data.kind == mlcs_pkg::KIND_MAP
        |=> !m_valid)
        else $error("result appeared before divide finished");

endmodule

bind minmax_linear_contrast_stretch mlcs_checker u_mlcs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
